FILE: rtl/efd_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and state codes of the escaped xor frame deframer
// no dependencies
package efd_pkg;

  localparam int FRAME_DEPTH_DEF = 32;

  localparam logic [7:0] HDR_BYTE = 8'hFA;
  localparam logic [7:0] ESC_BYTE = 8'hFE;
  localparam logic [7:0] ESC_HDR  = 8'h01;
  localparam logic [7:0] ESC_ESC  = 8'h02;
  localparam int         LEN_POS  = 5;
  localparam logic [7:0] MIN_LEN  = 8'd7;
  localparam logic [4:0] MAX_LEN_RST = 5'd29;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_t;

  typedef struct packed {
    logic       valid;
    logic       bank;
    logic [7:0] len;
  } commit_t;

  typedef struct packed {
    logic [1:0] busy;
  } status_t;

endpackage

FILE: rtl/efd_store.sv
`timescale 1ns / 1ps
// two-bank frame memory, one write and one registered read per cycle
// depends on efd_pkg for its default depth
module efd_store #(
  parameter int FRAME_DEPTH = efd_pkg::FRAME_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(FRAME_DEPTH):0]   wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(FRAME_DEPTH):0]   rd_addr,
  output logic [7:0]                     rd_data
);

  localparam int AW = $clog2(FRAME_DEPTH) + 1;

  logic [7:0] mem [2**AW];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/efd_front.sv
`timescale 1ns / 1ps
// front end: unescaping, frame collection, length and checksum checks
// depends on efd_pkg; writes frames into efd_store, hands finished ones to efd_back
module efd_front #(
  parameter int FRAME_DEPTH = efd_pkg::FRAME_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_raw_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [4:0]                    cfg_max_frame_len,
  input  efd_pkg::status_t              status,
  output logic                          wr_en,
  output logic [$clog2(FRAME_DEPTH):0]  wr_addr,
  output logic [7:0]                    wr_data,
  output efd_pkg::commit_t              commit
);

  localparam int IDXW = $clog2(FRAME_DEPTH);
  localparam int CW   = $clog2(FRAME_DEPTH + 1);

  logic          in_frame_r, in_frame_nxt;
  logic          esc_r, esc_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic          wr_bank_r, wr_bank_nxt;
  logic [4:0]    max_len_r;

  logic          go;
  logic          raw_en;
  logic [7:0]    raw_b;
  logic          data_en;
  logic [7:0]    data_b;
  logic          start_en;
  logic          bad_len;

  assign cfg_ready = 1'b1;
  assign go        = !status.busy[wr_bank_r];
  assign in_ready  = go && !pend_valid_r;

  // unescape and classify
  always_comb begin
    esc_nxt        = esc_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    raw_en         = 1'b0;
    raw_b          = in_raw_byte;
    data_en        = 1'b0;
    data_b         = in_raw_byte;
    start_en       = 1'b0;
    if (go && pend_valid_r) begin
      raw_en         = 1'b1;
      raw_b          = pend_byte_r;
      pend_valid_nxt = 1'b0;
    end else if (in_valid && in_ready) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        data_en = 1'b1;
        priority if (in_raw_byte == efd_pkg::ESC_HDR) begin
          data_b = efd_pkg::HDR_BYTE;
        end else if (in_raw_byte == efd_pkg::ESC_ESC) begin
          data_b = efd_pkg::ESC_BYTE;
        end else begin
          // lone escape: deliver fe now, hold the byte in pend_byte_r and replay it once go allows
          data_b         = efd_pkg::ESC_BYTE;
          pend_valid_nxt = 1'b1;
          pend_byte_nxt  = in_raw_byte;
        end
      end else begin
        raw_en = 1'b1;
      end
    end
    if (raw_en) begin
      priority if (raw_b == efd_pkg::HDR_BYTE) begin
        start_en = 1'b1;
      end else if (raw_b == efd_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        data_en = 1'b1;
        data_b  = raw_b;
      end
    end
  end

  assign bad_len = (data_b < efd_pkg::MIN_LEN) || (data_b > {3'b000, max_len_r}) ||
                   ({1'b0, data_b} > 9'(FRAME_DEPTH));

  // frame collection
  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    xor_nxt      = xor_r;
    wr_bank_nxt  = wr_bank_r;
    wr_en        = 1'b0;
    wr_addr      = {wr_bank_r, cnt_r[IDXW-1:0]};
    wr_data      = data_b;
    commit.valid = 1'b0;
    commit.bank  = wr_bank_r;
    commit.len   = len_r;
    if (start_en) begin
      in_frame_nxt = 1'b1;
      cnt_nxt      = CW'(1);
      xor_nxt      = efd_pkg::HDR_BYTE;
      len_nxt      = 8'd0;
      wr_en        = 1'b1;
      wr_addr      = {wr_bank_r, {IDXW{1'b0}}};
      wr_data      = efd_pkg::HDR_BYTE;
    end else if (data_en && in_frame_r) begin
      if (cnt_r >= CW'(FRAME_DEPTH)) begin
        in_frame_nxt = 1'b0;
      end else begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(efd_pkg::LEN_POS)) begin
          len_nxt = data_b;
          if (bad_len) begin
            in_frame_nxt = 1'b0;
          end else begin
            xor_nxt = xor_r ^ data_b;
          end
        end else if ((cnt_r > CW'(efd_pkg::LEN_POS)) &&
                     (9'(cnt_r) + 9'd1 == {1'b0, len_r})) begin
          in_frame_nxt = 1'b0;
          if (data_b == xor_r) begin
            commit.valid = 1'b1;
            wr_bank_nxt  = ~wr_bank_r;
          end
        end else begin
          xor_nxt = xor_r ^ data_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      esc_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
      len_r        <= 8'd0;
      xor_r        <= 8'd0;
      wr_bank_r    <= 1'b0;
      max_len_r    <= efd_pkg::MAX_LEN_RST;
    end else begin
      in_frame_r   <= in_frame_nxt;
      esc_r        <= esc_nxt;
      pend_valid_r <= pend_valid_nxt;
      cnt_r        <= cnt_nxt;
      len_r        <= len_nxt;
      xor_r        <= xor_nxt;
      wr_bank_r    <= wr_bank_nxt;
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_frame_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

FILE: rtl/efd_back.sv
`timescale 1ns / 1ps
// back end: two-entry frame queue and byte-by-byte readout with first/last marks
// depends on efd_pkg; reads frames from efd_store
module efd_back #(
  parameter int FRAME_DEPTH = efd_pkg::FRAME_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  efd_pkg::commit_t              commit,
  output efd_pkg::status_t              status,
  output logic                          rd_en,
  output logic [$clog2(FRAME_DEPTH):0]  rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_frame_byte,
  output logic                          out_frame_first,
  output logic                          out_frame_last
);

  localparam int IDXW = $clog2(FRAME_DEPTH);

  efd_pkg::back_state_t state_r, state_nxt;
  logic [1:0]      q_valid_r, q_valid_nxt;
  logic [7:0]      q_len_r [2];
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic            rd_bank_r, rd_bank_nxt;
  logic            is_last;

  assign is_last = (8'(idx_r) + 8'd1) == q_len_r[rd_bank_r];

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    rd_bank_nxt = rd_bank_r;
    q_valid_nxt = q_valid_r;
    unique case (state_r)
      efd_pkg::BK_IDLE: begin
        if (q_valid_r[rd_bank_r]) begin
          state_nxt = efd_pkg::BK_READ;
        end
      end
      efd_pkg::BK_READ: begin
        state_nxt = efd_pkg::BK_SHOW;
      end
      efd_pkg::BK_SHOW: begin
        if (out_ready) begin
          if (is_last) begin
            state_nxt              = efd_pkg::BK_IDLE;
            idx_nxt                = '0;
            rd_bank_nxt            = ~rd_bank_r;
            q_valid_nxt[rd_bank_r] = 1'b0;
          end else begin
            state_nxt = efd_pkg::BK_READ;
            idx_nxt   = idx_r + IDXW'(1);
          end
        end
      end
      default: begin
        state_nxt = efd_pkg::BK_IDLE;
      end
    endcase
    if (commit.valid) begin
      q_valid_nxt[commit.bank] = 1'b1;
    end
  end

  always_comb begin
    rd_en           = (state_r == efd_pkg::BK_READ);
    rd_addr         = {rd_bank_r, idx_r};
    out_valid       = (state_r == efd_pkg::BK_SHOW);
    out_frame_byte  = rd_data;
    out_frame_first = (idx_r == '0);
    out_frame_last  = is_last;
    status.busy     = q_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= efd_pkg::BK_IDLE;
      q_valid_r <= 2'b00;
      idx_r     <= '0;
      rd_bank_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      q_valid_r <= q_valid_nxt;
      idx_r     <= idx_nxt;
      rd_bank_r <= rd_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit.valid) begin
      q_len_r[commit.bank] <= commit.len;
    end
  end

endmodule

FILE: rtl/escaped_xor_frame_deframer_top.sv
`timescale 1ns / 1ps
// Escaped byte stream to verified frame bytes. Input bytes are taken one per cycle while
// in_ready is high. FE 01 and FE 02 unescape to FA and FE; a lone FE goes on as data and the
// byte behind it is replayed. A raw FA starts a frame, byte 5 gives its length, the last byte
// is the xor checksum. Good frames land in one of two memory banks and are read out byte by
// byte, a registered memory read then output held until out_ready. Input stalls while the bank
// being written holds an unread frame or a replay is pending. Bad frames produce nothing.
// depends on efd_pkg, efd_front, efd_store, efd_back
module escaped_xor_frame_deframer_top #(
  parameter int FRAME_DEPTH = efd_pkg::FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_raw_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_max_frame_len,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_first,
  output logic       out_frame_last
);

  localparam int AW = $clog2(FRAME_DEPTH) + 1;

  efd_pkg::commit_t commit;
  efd_pkg::status_t status;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  efd_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_byte       (in_raw_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_frame_len (cfg_max_frame_len),
    .status            (status),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .commit            (commit)
  );

  efd_store #(.FRAME_DEPTH(FRAME_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  efd_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .commit          (commit),
    .status          (status),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_byte  (out_frame_byte),
    .out_frame_first (out_frame_first),
    .out_frame_last  (out_frame_last)
  );

endmodule

FILE: dv/tb_escaped_xor_frame_deframer_top.sv
`timescale 1ns / 1ps
// testbench for escaped_xor_frame_deframer_top: escaped byte streams of good and broken frames,
// random gaps on both sides, every frame byte checked against an in-bench deframer
// depends on efd_pkg and the rtl of escaped_xor_frame_deframer_top
module tb_escaped_xor_frame_deframer_top;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } frame_beat_t;

  class deframe_scoreboard;
    frame_beat_t expected_frame_bytes[$];
    logic [7:0]  frame_buf[efd_pkg::FRAME_DEPTH_DEF];
    int          byte_count;
    logic [7:0]  frame_length;
    logic [7:0]  running_xor;
    bit          escape_pending;
    bit          in_frame;
    logic [4:0]  max_len;
    int          errors;

    function new();
      foreach (frame_buf[i]) frame_buf[i] = '0;
      byte_count = 0;
      frame_length = '0;
      running_xor = '0;
      escape_pending = 1'b0;
      in_frame = 1'b0;
      max_len = efd_pkg::MAX_LEN_RST;
      errors = 0;
    endfunction

    function void set_max_len(logic [4:0] v);
      max_len = v;
    endfunction

    function void take_data(logic [7:0] d);
      int pos;
      frame_beat_t beat;
      if (!in_frame) return;
      pos = byte_count;
      if (pos >= efd_pkg::FRAME_DEPTH_DEF) begin
        in_frame = 1'b0;
        return;
      end
      frame_buf[pos] = d;
      byte_count = (pos + 1) % 64;
      if (pos == efd_pkg::LEN_POS) begin
        frame_length = d;
        if (d < efd_pkg::MIN_LEN || d > {3'b000, max_len} || d > efd_pkg::FRAME_DEPTH_DEF) begin
          in_frame = 1'b0;
          return;
        end
      end
      if (pos > efd_pkg::LEN_POS && pos + 1 == frame_length) begin
        in_frame = 1'b0;
        if (d != running_xor) return;
        for (int k = 0; k < frame_length; k++) begin
          beat.data = frame_buf[k];
          beat.first = (k == 0);
          beat.last = (k + 1 == frame_length);
          expected_frame_bytes.push_back(beat);
        end
        return;
      end
      running_xor = running_xor ^ d;
    endfunction

    function void take_link_byte(logic [7:0] b);
      if (b == efd_pkg::HDR_BYTE) begin
        in_frame = 1'b1;
        byte_count = 1;
        frame_buf[0] = efd_pkg::HDR_BYTE;
        running_xor = efd_pkg::HDR_BYTE;
        frame_length = '0;
      end else if (b == efd_pkg::ESC_BYTE) begin
        escape_pending = 1'b1;
      end else begin
        take_data(b);
      end
    endfunction

    function void note_raw_byte(logic [7:0] b);
      if (escape_pending) begin
        escape_pending = 1'b0;
        if (b == efd_pkg::ESC_HDR) begin
          take_data(efd_pkg::HDR_BYTE);
        end else if (b == efd_pkg::ESC_ESC) begin
          take_data(efd_pkg::ESC_BYTE);
        end else begin
          // lone escape: the fe is data, the byte is taken on its own
          take_data(efd_pkg::ESC_BYTE);
          take_link_byte(b);
        end
      end else begin
        take_link_byte(b);
      end
    endfunction

    function void check_frame_byte(logic [7:0] data, logic first, logic last);
      frame_beat_t exp_beat;
      if (expected_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %02h first %0b last %0b", data, first, last);
        errors++;
        return;
      end
      exp_beat = expected_frame_bytes.pop_front();
      if (data !== exp_beat.data) begin
        $error("frame_byte: expected %02h, got %02h", exp_beat.data, data);
        errors++;
      end
      if (first !== exp_beat.first) begin
        $error("frame_first: expected %0b, got %0b", exp_beat.first, first);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("frame_last: expected %0b, got %0b", exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_raw_byte = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_max_frame_len = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_frame_first;
  logic       out_frame_last;

  deframe_scoreboard sb;
  byte_q_t           raw_stream;
  bit                steady = 1'b0;
  logic [4:0]        cur_max_len = efd_pkg::MAX_LEN_RST;

  escaped_xor_frame_deframer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_byte      (in_raw_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_frame_len(cfg_max_frame_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_frame_first  (out_frame_first),
    .out_frame_last   (out_frame_last)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] rand_data();
    case ($urandom_range(15))
      0, 1: return efd_pkg::HDR_BYTE;
      2, 3: return efd_pkg::ESC_BYTE;
      4: return efd_pkg::ESC_HDR;
      5: return efd_pkg::ESC_ESC;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void queue_escaped(logic [7:0] d);
    if (d == efd_pkg::HDR_BYTE) begin
      raw_stream.push_back(efd_pkg::ESC_BYTE);
      raw_stream.push_back(efd_pkg::ESC_HDR);
    end else if (d == efd_pkg::ESC_BYTE) begin
      raw_stream.push_back(efd_pkg::ESC_BYTE);
      raw_stream.push_back(efd_pkg::ESC_ESC);
    end else begin
      raw_stream.push_back(d);
    end
  endfunction

  // body holds bytes 1 .. L-2, the checksum is appended here
  function automatic void queue_frame(byte_q_t body, bit bad_sum, bit raw_fe_sum,
                                      int stray_at);
    logic [7:0] sum;
    sum = efd_pkg::HDR_BYTE;
    foreach (body[i]) sum = sum ^ body[i];
    if (raw_fe_sum) begin
      body[0] = body[0] ^ sum ^ efd_pkg::ESC_BYTE;
      sum = efd_pkg::ESC_BYTE;
    end
    raw_stream.push_back(efd_pkg::HDR_BYTE);
    foreach (body[i]) begin
      queue_escaped(body[i]);
      if (i == stray_at) begin
        raw_stream.push_back(efd_pkg::ESC_BYTE);
        raw_stream.push_back(rand_data());
      end
    end
    if (raw_fe_sum) begin
      // unescaped fe as checksum, closed by the next header
      raw_stream.push_back(efd_pkg::ESC_BYTE);
      raw_stream.push_back(efd_pkg::HDR_BYTE);
    end else begin
      queue_escaped(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
    end
  endfunction

  function automatic byte_q_t frame_body(logic [7:0] len_field, int size);
    byte_q_t body;
    for (int i = 0; i < size; i++) body.push_back(rand_data());
    if (size > 4) body[4] = len_field;
    return body;
  endfunction

  function automatic int pick_good_len();
    int hi;
    hi = (cur_max_len < efd_pkg::MIN_LEN) ? 12 : cur_max_len;
    if ($urandom_range(7) != 0 && hi > 12) hi = 12;
    return $urandom_range(hi, 7);
  endfunction

  task automatic send_stream();
    logic [7:0] b;
    while (raw_stream.size() != 0) begin
      b = raw_stream.pop_front();
      while (!steady && $urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_raw_byte <= b;
      do @(posedge clk); while (!in_ready);
      sb.note_raw_byte(b);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic set_max_len(input logic [4:0] v);
    while (sb.expected_frame_bytes.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_max_frame_len <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_max_len(v);
    cur_max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int item_goal);
    int      items;
    int      kind;
    int      len;
    int      cut;
    byte_q_t body;
    items = 0;
    while (items < item_goal) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        // line noise between frames
        repeat ($urandom_range(4, 1)) raw_stream.push_back(8'($urandom_range(255)));
      end else if (kind < 14) begin
        case ($urandom_range(2))
          0: len = $urandom_range(6, 0);
          1: len = (cur_max_len < 31) ? $urandom_range(31, cur_max_len + 1) : 40;
          default: len = $urandom_range(255, 33);
        endcase
        body = frame_body(8'(len), $urandom_range(10, 5));
        queue_frame(body, 1'b0, 1'b0, -1);
        items += body.size() + 2;
      end else if (kind < 22) begin
        // cut short, the next header restarts
        len = pick_good_len();
        body = frame_body(8'(len), len - 2);
        cut = $urandom_range(len - 3, 0);
        raw_stream.push_back(efd_pkg::HDR_BYTE);
        for (int i = 0; i < cut; i++) queue_escaped(body[i]);
        items += cut + 1;
      end else begin
        len = pick_good_len();
        body = frame_body(8'(len), len - 2);
        queue_frame(body, kind < 30, kind >= 30 && kind < 36,
                    (kind >= 36 && kind < 42) ? $urandom_range(len - 3, 0) : -1);
        items += len;
      end
    end
    raw_stream.push_back(8'h00);
    send_stream();
  endtask

  // result side: check, then decide ready for the next cycle
  initial begin
    int beats_seen;
    int hold_left;
    bit held;
    beats_seen = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_frame_byte(out_frame_byte, out_frame_first, out_frame_last);
        beats_seen++;
      end
      @(negedge clk);
      if (!held && beats_seen >= 100) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin
    byte_q_t body;
    sb = new();
    rst_n <= 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // escaped header and lone escapes while hunting, then a lone fe before a header
    raw_stream = {efd_pkg::ESC_BYTE, efd_pkg::ESC_HDR, efd_pkg::ESC_BYTE, 8'hFF, 8'h00,
                  efd_pkg::ESC_BYTE, efd_pkg::HDR_BYTE, 8'h11};
    body = {efd_pkg::ESC_BYTE, efd_pkg::HDR_BYTE, 8'hFF, 8'h00, 8'd7};
    queue_frame(body, 1'b0, 1'b0, -1);
    body = {8'h01, 8'h02, 8'h03, 8'h04, 8'd7};
    queue_frame(body, 1'b1, 1'b0, -1);
    body = {8'h00, 8'h00, 8'h00, 8'h00, 8'd6};
    queue_frame(body, 1'b0, 1'b0, -1);
    send_stream();

    set_max_len(5'd7);
    run_random_phase(50);
    steady = 1'b1;
    set_max_len(5'd31);
    run_random_phase(90);
    steady = 1'b0;
    set_max_len(5'd5);
    run_random_phase(30);
    set_max_len(5'd18);
    run_random_phase(80);
    repeat (2) begin
      set_max_len(5'($urandom_range(31, 7)));
      run_random_phase(75);
    end

    while (sb.expected_frame_bytes.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.expected_frame_bytes.size() == 0) begin
      $display("escaped_xor_frame_deframer_top test passed");
    end else begin
      $display("escaped_xor_frame_deframer_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("escaped_xor_frame_deframer_top test failed");
    $finish;
  end

endmodule
